@@ design/id3pe_pkg.sv @@
// Package for the ID3v2 picture frame extractor: payload types, codes and constants.
package id3pe_pkg;

	// Default width of the file offset counter
	localparam int OFFSET_BITS_DEF = 34;

	// Outcome codes of a result transfer
	localparam logic [1:0] OUT_MORE = 2'd0;
	localparam logic [1:0] OUT_DONE = 2'd1;
	localparam logic [1:0] OUT_NONE = 2'd2;

	// Parse phases
	localparam logic [2:0] PH_TAG   = 3'd0;
	localparam logic [2:0] PH_FRAME = 3'd1;
	localparam logic [2:0] PH_SKIP  = 3'd2;
	localparam logic [2:0] PH_BODY  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	// Picture frame body phases
	localparam logic [2:0] BD_ENC  = 3'd0;
	localparam logic [2:0] BD_MIME = 3'd1;
	localparam logic [2:0] BD_TYPE = 3'd2;
	localparam logic [2:0] BD_DESC = 3'd3;
	localparam logic [2:0] BD_DATA = 3'd4;

	// Tag mark and picture frame id
	localparam logic [7:0] CHR_I = 8'h49;
	localparam logic [7:0] CHR_D = 8'h44;
	localparam logic [7:0] CHR_3 = 8'h33;
	localparam logic [31:0] APIC_ID = 32'h41504943;
	localparam logic [31:0] HDR_BYTES = 32'd10;

	// One input item
	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} item_t;

	// One result item
	typedef struct packed {
		logic [7:0] image_byte;
		logic       has_byte;
		logic       final_res;
		logic [1:0] outcome;
	} result_t;

	// Result with its valid flag, from parser to output stage
	typedef struct packed {
		logic    valid;
		result_t data;
	} res_vld_t;

endpackage

@@ design/id3pe_in_stage.sv @@
// Input register stage of the picture frame extractor.
module id3pe_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  id3pe_pkg::item_t item,
	input  logic          adv,
	output logic          valid_s1,
	output id3pe_pkg::item_t item_s1
);
	import id3pe_pkg::*;

	logic load;

	// Hold the item only while the parser cannot move it on
	assign item_stall = valid_s1 & ~adv;
	assign load       = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

@@ design/id3pe_parser.sv @@
// Parser state and per-byte decode logic of the picture frame extractor.
module id3pe_parser #(
	parameter int OFFSET_BITS = id3pe_pkg::OFFSET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  id3pe_pkg::item_t item_s1,
	input  logic             out_free,
	output logic             adv,
	output id3pe_pkg::res_vld_t res
);
	import id3pe_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	logic [2:0]             phase_q, phase_d;
	logic [2:0]             body_q, body_d;
	logic [3:0]             hdr_cnt_q, hdr_cnt_d;
	logic [27:0]            tag_size_q, tag_size_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc;
	logic [63:0]            hdr_bits_q, hdr_bits_d;
	logic [31:0]            left_q, left_d, left_dec;
	logic [27:0]            tag_shift, cmp_size;
	logic                   room, last, mark_bad;
	logic [7:0]             b;

	assign adv = valid_s1 & out_free;
	assign b   = item_s1.file_byte;

	// Offset, tag size and frame count arithmetic
	assign pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign tag_shift = {tag_size_q[20:0], b[6:0]};
	assign cmp_size  = (phase_q == PH_TAG) ? tag_shift : tag_size_q;
	// header fits before tag end: pos + 10 <= size + 10
	assign room      = pos_inc <= OFFSET_BITS'(cmp_size);
	assign left_dec  = (left_q == 32'd0) ? 32'd0 : left_q - 32'd1;
	assign last      = left_q <= 32'd1;
	assign mark_bad  = ((hdr_cnt_q == 4'd0) && (b != CHR_I)) ||
		((hdr_cnt_q == 4'd1) && (b != CHR_D)) ||
		((hdr_cnt_q == 4'd2) && (b != CHR_3));

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		body_d     = body_q;
		hdr_cnt_d  = hdr_cnt_q;
		tag_size_d = tag_size_q;
		pos_d      = pos_q;
		hdr_bits_d = hdr_bits_q;
		left_d     = left_q;
		res        = '0;
		res.data.outcome = OUT_MORE;

		if (phase_q != PH_DONE) begin
			pos_d = pos_inc;
			case (phase_q)
				PH_TAG: begin
					if (mark_bad) begin
						res.valid = 1'b1;
						res.data.final_res = 1'b1;
						res.data.outcome = OUT_NONE;
						phase_d = PH_DONE;
					end else begin
						if (hdr_cnt_q >= 4'd6) begin
							tag_size_d = tag_shift;
						end
						hdr_cnt_d = hdr_cnt_q + 4'd1;
						if (hdr_cnt_q == 4'd9) begin
							if (room) begin
								phase_d    = PH_FRAME;
								hdr_cnt_d  = 4'd0;
								hdr_bits_d = '0;
							end else begin
								res.valid = 1'b1;
								res.data.final_res = 1'b1;
								res.data.outcome = OUT_NONE;
								phase_d = PH_DONE;
							end
						end
					end
				end
				PH_FRAME: begin
					if (hdr_cnt_q < 4'd8) begin
						hdr_bits_d = {hdr_bits_q[55:0], b};
					end
					hdr_cnt_d = hdr_cnt_q + 4'd1;
					if (hdr_cnt_q == 4'd9) begin
						if (hdr_bits_q[63:32] == APIC_ID) begin
							if (hdr_bits_q[31:0] > HDR_BYTES) begin
								phase_d = PH_BODY;
								body_d  = BD_ENC;
								left_d  = hdr_bits_q[31:0];
							end else begin
								res.valid = 1'b1;
								res.data.final_res = 1'b1;
								res.data.outcome = OUT_NONE;
								phase_d = PH_DONE;
							end
						end else if (hdr_bits_q[31:0] == 32'd0) begin
							res.valid = 1'b1;
							res.data.final_res = 1'b1;
							res.data.outcome = OUT_NONE;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_SKIP;
							left_d  = hdr_bits_q[31:0];
						end
					end
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == 32'd0) begin
						if (room) begin
							phase_d    = PH_FRAME;
							hdr_cnt_d  = 4'd0;
							hdr_bits_d = '0;
						end else begin
							res.valid = 1'b1;
							res.data.final_res = 1'b1;
							res.data.outcome = OUT_NONE;
							phase_d = PH_DONE;
						end
					end
				end
				PH_BODY: begin
					left_d = left_dec;
					case (body_q)
						BD_ENC:  body_d = BD_MIME;
						BD_MIME: if (b == 8'd0) body_d = BD_TYPE;
						BD_TYPE: body_d = BD_DESC;
						BD_DESC: if (b == 8'd0) body_d = BD_DATA;
						default: ;
					endcase
					if (body_q == BD_DATA) begin
						res.valid = 1'b1;
						res.data.has_byte = 1'b1;
						res.data.image_byte = b;
						if (last) begin
							res.data.final_res = 1'b1;
							res.data.outcome = OUT_DONE;
							phase_d = PH_DONE;
						end
					end else if (last) begin
						// frame ran out before the picture data
						res.valid = 1'b1;
						res.data.final_res = 1'b1;
						res.data.outcome = OUT_NONE;
						phase_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		// End of file: close the file if no final result yet, then rearm
		if (item_s1.end_of_file) begin
			if (phase_d != PH_DONE) begin
				res.valid = 1'b1;
				res.data.final_res = 1'b1;
				res.data.outcome = OUT_NONE;
			end
			phase_d    = PH_TAG;
			body_d     = BD_ENC;
			hdr_cnt_d  = 4'd0;
			tag_size_d = '0;
			pos_d      = '0;
			hdr_bits_d = '0;
			left_d     = '0;
		end

		if (!adv) begin
			res.valid = 1'b0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			body_q     <= BD_ENC;
			hdr_cnt_q  <= 4'd0;
			tag_size_q <= '0;
			pos_q      <= '0;
			hdr_bits_q <= '0;
			left_q     <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			body_q     <= body_d;
			hdr_cnt_q  <= hdr_cnt_d;
			tag_size_q <= tag_size_d;
			pos_q      <= pos_d;
			hdr_bits_q <= hdr_bits_d;
			left_q     <= left_d;
		end
	end

	// Checks
	a_byte_from_body: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.has_byte |-> phase_q == PH_BODY && body_q == BD_DATA)
		else $error("image byte outside picture data");

	a_done_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.outcome == OUT_DONE |-> res.data.has_byte && res.data.final_res)
		else $error("complete outcome without a last picture byte");

	a_final_parks: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.final_res && !item_s1.end_of_file |=> phase_q == PH_DONE)
		else $error("parser not parked after final result");

	a_eof_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.end_of_file |=> phase_q == PH_TAG && hdr_cnt_q == 4'd0 && pos_q == '0)
		else $error("parser not rearmed after end of file");

	a_silent_when_parked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && !item_s1.end_of_file |-> !res.valid)
		else $error("result after final result");

endmodule

@@ design/id3pe_out_stage.sv @@
// Result register stage of the picture frame extractor.
module id3pe_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  id3pe_pkg::res_vld_t res,
	output logic                out_free,
	output logic                result_valid,
	input  logic                result_stall,
	output id3pe_pkg::result_t  result
);
	import id3pe_pkg::*;

	logic    valid_q;
	result_t result_q;

	// Register may take a new result when empty or being drained
	assign out_free     = ~valid_q | ~result_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			result_q <= res.data;
		end
	end

endmodule

@@ design/id3v2_picture_frame_extractor.sv @@
// Top level of the ID3v2 picture frame extractor.
// Reads an audio file one byte per transfer and streams out the payload of the first APIC
// frame of its ID3v2 tag, with a final result marking picture complete or not found.
// One byte is taken every clock cycle: a byte waits in the input register while
// the frame walk, offset counter and tag-end compare decide its result, which lands in the
// result register and is offered from there. The only pause is back-pressure from the
// result side.
module id3v2_picture_frame_extractor #(
	parameter int OFFSET_BITS = id3pe_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  id3pe_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output id3pe_pkg::result_t result
);
	import id3pe_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     adv;
	logic     out_free;
	res_vld_t res;

	id3pe_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	id3pe_parser #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.adv      (adv),
		.res      (res)
	);

	id3pe_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the ID3v2 picture frame extractor: directed byte table, then random files.
module testbench;
	import id3pe_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 10;

	// Not-found result as it stands after a bad mark, an empty tag or an early end of file
	localparam result_t NOT_FOUND_RES = '{image_byte: 8'h00, has_byte: 1'b0, final_res: 1'b1,
		outcome: OUT_NONE};

	// How a directed row gets its expectation
	typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_NOT_FOUND} row_kind_t;

	typedef struct packed {
		item_t     it;
		row_kind_t kind;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int send_idle_pct = 37;
	int recv_idle_pct = 52;

	int cycle_count = 0;
	int items_sent = 0;
	int files_sent = 0;
	int results_checked = 0;
	int pictures_done = 0;
	int not_found_seen = 0;
	int mismatch_count = 0;

	row_t       directed_rows[$];
	result_t    extract_out_q[$];
	logic [7:0] file_bytes[$];
	logic [7:0] tag_frames[$];

	// Byte-walk predictor state
	logic [2:0]                 walk_phase;
	logic [2:0]                 body_step;
	logic [3:0]                 hdr_count;
	logic [31:0]                tag_end;
	logic [OFFSET_BITS_DEF-1:0] file_pos;
	logic [63:0]                hdr_bits;
	logic [31:0]                bytes_left;
	logic                       done_flag;
	logic                       walk_gives;
	result_t                    walk_res;

	always #5 clk = ~clk;

	id3v2_picture_frame_extractor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Back to the start-of-file state
	function automatic void rearm_walk();
		walk_phase = PH_TAG;
		hdr_count  = '0;
		tag_end    = '0;
		file_pos   = '0;
		hdr_bits   = '0;
		bytes_left = '0;
		body_step  = BD_ENC;
		done_flag  = 1'b0;
	endfunction

	function automatic void flag_not_found();
		walk_gives         = 1'b1;
		walk_res.final_res = 1'b1;
		walk_res.outcome   = OUT_NONE;
		done_flag          = 1'b1;
		walk_phase         = PH_DONE;
	endfunction

	// Next frame header only if a whole one still fits in the tag
	function automatic void open_frame();
		if (64'(file_pos) + 64'd10 <= 64'(tag_end)) begin
			walk_phase = PH_FRAME;
			hdr_count  = '0;
			hdr_bits   = '0;
		end else begin
			flag_not_found();
		end
	endfunction

	// Advance the predictor by one file byte; walk_gives/walk_res hold the result it causes
	function automatic void walk_tag_byte(input item_t it);
		logic [7:0] b;
		logic       body_end;
		b          = it.file_byte;
		walk_gives = 1'b0;
		walk_res   = '0;
		if (!done_flag && walk_phase != PH_DONE) begin
			if (file_pos != '1)
				file_pos++;
			case (walk_phase)
				PH_TAG: begin
					if ((hdr_count == 4'd0 && b != CHR_I) || (hdr_count == 4'd1 && b != CHR_D) ||
							(hdr_count == 4'd2 && b != CHR_3)) begin
						flag_not_found();
					end else begin
						// syncsafe size, seven bits per byte
						if (hdr_count >= 4'd6)
							tag_end = ((tag_end << 7) | {25'd0, b[6:0]}) & 32'h0fff_ffff;
						hdr_count++;
						if (hdr_count == 4'd10) begin
							tag_end += HDR_BYTES;
							open_frame();
						end
					end
				end
				PH_FRAME: begin
					if (hdr_count < 4'd8)
						hdr_bits = {hdr_bits[55:0], b};
					hdr_count++;
					if (hdr_count == 4'd10) begin
						if (hdr_bits[63:32] == APIC_ID) begin
							if (hdr_bits[31:0] > HDR_BYTES) begin
								walk_phase = PH_BODY;
								body_step  = BD_ENC;
								bytes_left = hdr_bits[31:0];
							end else begin
								flag_not_found();
							end
						end else if (hdr_bits[31:0] == 32'd0) begin
							flag_not_found();
						end else begin
							walk_phase = PH_SKIP;
							bytes_left = hdr_bits[31:0];
						end
					end
				end
				PH_SKIP: begin
					if (bytes_left != 0)
						bytes_left--;
					if (bytes_left == 0)
						open_frame();
				end
				default: begin
					// picture frame body
					if (bytes_left != 0)
						bytes_left--;
					body_end = (bytes_left == 0);
					case (body_step)
						BD_ENC: body_step = BD_MIME;
						BD_MIME: if (b == 8'h00) body_step = BD_TYPE;
						BD_TYPE: body_step = BD_DESC;
						BD_DESC: if (b == 8'h00) body_step = BD_DATA;
						default: begin
							walk_gives          = 1'b1;
							walk_res.has_byte   = 1'b1;
							walk_res.image_byte = b;
							if (body_end) begin
								walk_res.final_res = 1'b1;
								walk_res.outcome   = OUT_DONE;
								done_flag          = 1'b1;
								walk_phase         = PH_DONE;
							end
							body_end = 1'b0;
						end
					endcase
					if (body_end)
						flag_not_found();
				end
			endcase
		end
		// end of file closes any open search, keeping a picture byte of the same step
		if (it.end_of_file) begin
			if (!done_flag) begin
				walk_gives         = 1'b1;
				walk_res.final_res = 1'b1;
				walk_res.outcome   = OUT_NONE;
			end
			rearm_walk();
		end
	endfunction

	function automatic void add_row(input logic [7:0] b, input logic eof, input row_kind_t kind);
		row_t r;
		r.it.file_byte   = b;
		r.it.end_of_file = eof;
		r.kind           = kind;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_frame_header(input logic [31:0] id, input logic [31:0] size);
		for (int k = 3; k >= 0; k--)
			tag_frames.push_back(id[8*k +: 8]);
		for (int k = 3; k >= 0; k--)
			tag_frames.push_back(size[8*k +: 8]);
		tag_frames.push_back(8'($urandom));
		tag_frames.push_back(8'($urandom));
	endfunction

	// Random file: mostly a tag with a picture frame, some noise and broken layouts
	task automatic build_file();
		int          n_pre;
		int          mime_len;
		int          desc_len;
		int          data_len;
		int          cut;
		logic [31:0] id;
		logic [31:0] fsz;
		logic [31:0] tag_size;
		bit          huge;
		file_bytes.delete();
		tag_frames.delete();
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 6))
				file_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1))
				file_bytes[0] = CHR_I;
			if (file_bytes.size() > 1 && $urandom_range(0, 1))
				file_bytes[1] = CHR_D;
			return;
		end

		// frames ahead of the picture, some with ids one bit off
		huge  = ($urandom_range(0, 19) == 0);
		n_pre = huge ? $urandom_range(1, 2) : $urandom_range(0, 2);
		for (int f = 0; f < n_pre; f++) begin
			id  = $urandom_range(0, 1) ? 32'($urandom) : APIC_ID ^ (32'd1 << $urandom_range(0, 31));
			fsz = $urandom_range(1, 6);
			if ($urandom_range(0, 14) == 0)
				fsz = 32'd0;
			if (huge && f == 0)
				fsz = 32'($urandom) | 32'h8000_0000;
			add_frame_header(id, fsz);
			repeat ((fsz > 6) ? 6 : fsz)
				tag_frames.push_back(8'($urandom));
		end

		// picture frame
		mime_len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
		desc_len = $urandom_range(0, 4);
		data_len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 16);
		fsz      = 4 + mime_len + desc_len + data_len;
		if ($urandom_range(0, 9) == 0)
			fsz = $urandom_range(0, 10);
		add_frame_header(APIC_ID, fsz);
		tag_frames.push_back(8'($urandom));
		repeat (mime_len)
			tag_frames.push_back(8'($urandom_range(1, 255)));
		tag_frames.push_back(8'h00);
		tag_frames.push_back(8'($urandom));
		repeat (desc_len)
			tag_frames.push_back(8'($urandom_range(1, 255)));
		tag_frames.push_back(8'h00);
		repeat (data_len)
			tag_frames.push_back(8'($urandom));

		// tag header, size usually just covering the frames
		tag_size = tag_frames.size() + $urandom_range(0, 4);
		if ($urandom_range(0, 9) == 0)
			tag_size = $urandom_range(0, tag_frames.size());
		if ($urandom_range(0, 19) == 0)
			tag_size = 32'h0fff_ffff;
		file_bytes.push_back(CHR_I);
		file_bytes.push_back(CHR_D);
		file_bytes.push_back(CHR_3);
		repeat (3)
			file_bytes.push_back(8'($urandom));
		for (int s = 3; s >= 0; s--)
			file_bytes.push_back({1'($urandom), tag_size[7*s +: 7]});
		if ($urandom_range(0, 19) == 0)
			file_bytes[$urandom_range(0, 2)] = 8'($urandom);
		foreach (tag_frames[k])
			file_bytes.push_back(tag_frames[k]);

		// padding and audio, sometimes a truncated file
		repeat ($urandom_range(0, 3))
			file_bytes.push_back(8'h00);
		repeat ($urandom_range(0, 4))
			file_bytes.push_back(8'($urandom));
		if ($urandom_range(0, 6) == 0) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endtask

	// One byte transfer, with random idle cycles ahead of it
	task automatic send_item(input item_t next, input row_kind_t kind);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= next;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		walk_tag_byte(next);
		case (kind)
			ROW_PREDICT: if (walk_gives) extract_out_q.push_back(walk_res);
			ROW_NOT_FOUND: extract_out_q.push_back(NOT_FOUND_RES);
			default: ;
		endcase
		items_sent++;
	endtask

	// Result side: check each transfer, then pick the stall for the next cycle
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (extract_out_q.size() == 0) begin
				$error("result transfer with nothing outstanding: %h", result);
				mismatch_count++;
			end else begin
				want = extract_out_q.pop_front();
				if (want.image_byte !== result.image_byte) begin
					$error("image_byte: expected %h, got %h", want.image_byte, result.image_byte);
					mismatch_count++;
				end
				if (want.has_byte !== result.has_byte) begin
					$error("has_byte: expected %b, got %b", want.has_byte, result.has_byte);
					mismatch_count++;
				end
				if (want.final_res !== result.final_res) begin
					$error("final_res: expected %b, got %b", want.final_res, result.final_res);
					mismatch_count++;
				end
				if (want.outcome !== result.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
					mismatch_count++;
				end
				results_checked++;
				if (want.outcome == OUT_DONE)
					pictures_done++;
				if (want.outcome == OUT_NONE)
					not_found_seen++;
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		item_t next;
		int    phase_items;
		rearm_walk();

		// bad mark on the first byte, then a byte ignored up to end of file
		add_row(8'h41, 1'b0, ROW_NOT_FOUND);
		add_row(8'hff, 1'b1, ROW_SILENT);
		// bad third mark byte
		add_row(CHR_I, 1'b0, ROW_PREDICT);
		add_row(CHR_D, 1'b0, ROW_PREDICT);
		add_row(8'h00, 1'b0, ROW_NOT_FOUND);
		add_row(8'h00, 1'b1, ROW_SILENT);
		// end of file on the very first byte
		add_row(CHR_I, 1'b1, ROW_NOT_FOUND);
		// empty tag with masked size bits: no room for a frame header
		add_row(CHR_I, 1'b0, ROW_PREDICT);
		add_row(CHR_D, 1'b0, ROW_PREDICT);
		add_row(CHR_3, 1'b0, ROW_PREDICT);
		add_row(8'hff, 1'b0, ROW_PREDICT);
		add_row(8'h00, 1'b0, ROW_PREDICT);
		add_row(8'hff, 1'b0, ROW_PREDICT);
		add_row(8'h80, 1'b0, ROW_PREDICT);
		add_row(8'h80, 1'b0, ROW_PREDICT);
		add_row(8'h80, 1'b0, ROW_PREDICT);
		add_row(8'h80, 1'b0, ROW_NOT_FOUND);
		add_row(8'h5a, 1'b1, ROW_SILENT);
		// end of file inside the tag header
		add_row(CHR_I, 1'b0, ROW_PREDICT);
		add_row(CHR_D, 1'b0, ROW_PREDICT);
		add_row(CHR_3, 1'b0, ROW_PREDICT);
		add_row(8'h04, 1'b0, ROW_PREDICT);
		add_row(8'h00, 1'b1, ROW_NOT_FOUND);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_item(directed_rows[r].it, directed_rows[r].kind);

		// random files over three idling phases
		while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
			build_file();
			for (int i = 0; i < file_bytes.size(); i++) begin
				phase_items = items_sent - directed_rows.size();
				if (phase_items < RANDOM_ITEMS / 3) begin
					send_idle_pct = 37;
					recv_idle_pct = 52;
				end else if (phase_items < 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 52;
					recv_idle_pct = 37;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				next.file_byte   = file_bytes[i];
				next.end_of_file = (i == file_bytes.size() - 1);
				send_item(next, ROW_PREDICT);
			end
			files_sent++;
		end
		item_valid <= 1'b0;

		// drain, then a few more cycles for anything stray
		while (extract_out_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d random files plus a directed table, %0d byte transfers in total",
			files_sent, items_sent);
		$display("%0d results checked: %0d pictures complete, %0d not found",
			results_checked, pictures_done, not_found_seen);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
